@@ rtl/gtrav_pkg.sv @@
// shared constants for the adjacency-matrix graph traversal unit
// no dependencies; imported by gtrav_pick and adjacency_matrix_bfs_dfs_unit
package gtrav_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VIDX_W + 1;
  localparam int ROW_W        = 16;
  localparam int OP_W         = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_BFS  = 2'd1;
  localparam logic [OP_W-1:0] OP_DFS  = 2'd2;

  // reset value of the vertex count register
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_VERTICES);

endpackage

@@ rtl/gtrav_pick.sv @@
// lowest-set-bit picker over a candidate vertex mask
// depends on gtrav_pkg
module gtrav_pick
  import gtrav_pkg::*;
(
  input  logic [MAX_VERTICES-1:0] cand,
  output logic                    found,
  output logic [VIDX_W-1:0]       idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        idx   = VIDX_W'(i);
      end
    end
  end

endmodule

@@ rtl/adjacency_matrix_bfs_dfs_unit.sv @@
// top level of the adjacency-matrix breadth-first / depth-first traversal unit
// depends on gtrav_pkg and gtrav_pick
//
// usage
//   command channel: a transaction is taken at a clock edge where start is high
//   and busy is low. operation selects load row, breadth-first or depth-first.
//   load writes row_bits into adjacency row row_index, no result,
//   busy stays low. an unused operation code is dropped.
//   a traversal with start_vertex at or above the vertex count gives a single
//   error result (vertex 0, last and error set) in the next cycle, busy stays low.
//   otherwise busy rises and the unit walks the graph: for each popped vertex
//   the POP state pops the work list, the FETCH state reads the adjacency row,
//   then the SCAN state takes newly discovered neighbours one by one and closes
//   when none is left. the scan shares one lowest-set-bit picker.
//   results: result_valid strobes for one cycle with vertex, last and error;
//   the receiver cannot stall, each result is taken in the cycle it is shown.
//   the final vertex carries last. visited marks are cleared at the end.
//   configuration: cfg_we writes cfg_data into the vertex count; the user writes
//   it only while idle, unenforced. values above MAX_VERTICES behave as MAX_VERTICES.
//   reset (rst, synchronous): no edges, vertex count 16, unit idle.
module adjacency_matrix_bfs_dfs_unit
  import gtrav_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // command transaction
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation,
  input  logic [VIDX_W-1:0] row_index,
  input  logic [ROW_W-1:0]  row_bits,
  input  logic [VIDX_W-1:0] start_vertex,
  // configuration
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  // result transaction
  output logic              result_valid,
  output logic [VIDX_W-1:0] vertex,
  output logic              last,
  output logic              error
);

  // sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0]              state;
  logic                    lifo;
  logic [CNT_W-1:0]        vertex_count;
  logic [MAX_VERTICES-1:0] visited;
  logic [CNT_W-1:0]        head;
  logic [CNT_W-1:0]        tail;
  logic [VIDX_W-1:0]       pend;
  logic                    have_pend;

  // adjacency rows, with per-row valid bits standing in for the cleared reset
  logic [ROW_W-1:0]        adj [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [ROW_W-1:0]        row_q;

  // work list (fifo for breadth-first, stack for depth-first)
  logic [VIDX_W-1:0]       work_list [MAX_VERTICES];
  logic [VIDX_W-1:0]       wl_q;
  logic                    wl_we;
  logic [VIDX_W-1:0]       wl_waddr;
  logic [VIDX_W-1:0]       wl_wdata;
  logic [VIDX_W-1:0]       wl_raddr;
  logic [CNT_W-1:0]        tail_dec;

  logic [CNT_W-1:0]        n_eff;
  logic [ROW_W:0]          lim_full;
  logic [MAX_VERTICES-1:0] lim_mask;
  logic [MAX_VERTICES-1:0] cand;
  logic                    found;
  logic [VIDX_W-1:0]       pick_idx;

  logic                    accept;
  logic                    is_trav;
  logic                    start_ok;
  logic                    list_room;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign is_trav = (operation == OP_BFS) || (operation == OP_DFS);

  // saturate the vertex count to the matrix size
  assign n_eff = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vertex_count;
  assign start_ok = ({1'b0, start_vertex} < n_eff);

  // vertices at or above the count are never reached
  assign lim_full = ((ROW_W + 1)'(1) << n_eff) - (ROW_W + 1)'(1);
  assign lim_mask = lim_full[MAX_VERTICES-1:0];

  // unvisited neighbours of the current vertex, one picked per scan cycle
  assign cand = row_q[MAX_VERTICES-1:0] & ~visited & lim_mask;

  gtrav_pick u_pick (
    .cand  (cand),
    .found (found),
    .idx   (pick_idx)
  );

  assign list_room = (tail < n_eff);
  assign tail_dec  = tail - CNT_W'(1);
  assign wl_raddr  = lifo ? tail_dec[VIDX_W-1:0] : head[VIDX_W-1:0];

  // work list writes: seed vertex at start, discovered neighbours while scanning
  always_comb begin
    wl_we    = 1'b0;
    wl_waddr = '0;
    wl_wdata = start_vertex;
    if (state == S_IDLE) begin
      wl_we = accept && is_trav && start_ok;
    end else if (state == S_SCAN) begin
      wl_we    = found && list_room;
      wl_waddr = tail[VIDX_W-1:0];
      wl_wdata = pick_idx;
    end
  end

  // memories, read data registered
  always_ff @(posedge clk) begin
    if (wl_we) begin
      work_list[wl_waddr] <= wl_wdata;
    end
    if (state == S_POP) begin
      wl_q <= work_list[wl_raddr];
    end
    if (accept && (operation == OP_LOAD)) begin
      adj[row_index] <= row_bits;
    end
    if (state == S_FETCH) begin
      row_q <= row_valid[wl_q] ? adj[wl_q] : '0;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lifo         <= 1'b0;
      vertex_count <= COUNT_RESET;
      visited      <= '0;
      head         <= '0;
      tail         <= '0;
      have_pend    <= 1'b0;
      row_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == OP_LOAD) begin
              row_valid[row_index] <= 1'b1;
            end else if (is_trav) begin
              lifo <= (operation == OP_DFS);
              if (!start_ok) begin
                // out-of-range start: single error result
                result_valid <= 1'b1;
                vertex       <= '0;
                last         <= 1'b1;
                error        <= 1'b1;
              end else begin
                head      <= '0;
                tail      <= CNT_W'(1);
                visited   <= MAX_VERTICES'(1) << start_vertex;
                have_pend <= 1'b0;
                state     <= S_POP;
              end
            end
          end
        end
        S_POP: begin
          if (head < tail) begin
            if (lifo) begin
              tail <= tail_dec;
            end else begin
              head <= head + CNT_W'(1);
            end
            state <= S_FETCH;
          end else begin
            // list exhausted: the held vertex is the final one
            result_valid <= 1'b1;
            vertex       <= pend;
            last         <= 1'b1;
            error        <= 1'b0;
            visited      <= '0;
            head         <= '0;
            tail         <= '0;
            state        <= S_IDLE;
          end
        end
        S_FETCH: begin
          // previous vertex is now known not to be the last
          if (have_pend) begin
            result_valid <= 1'b1;
            vertex       <= pend;
            last         <= 1'b0;
            error        <= 1'b0;
          end
          pend      <= wl_q;
          have_pend <= 1'b1;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          if (found) begin
            if (list_room) begin
              tail <= tail + CNT_W'(1);
            end
            visited[pick_idx] <= 1'b1;
          end else begin
            state <= S_POP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an error result always closes its traversal
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && error) |-> last)
    else $error("error result without last");

  // visited marks are clear whenever the unit is idle
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (visited == '0))
    else $error("visited marks left set while idle");

  // a non-final vertex means the traversal is still running
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("non-final result with unit idle");

  // the work list never grows past the matrix size
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= CNT_W'(MAX_VERTICES))
    else $error("work list overflow");

endmodule
